// ----- hw/rtl/jsc_pkg.sv -----
// Package: constants, widths and result beat type shared by the JPEG stream carver files.
package jsc_pkg;

  // Marker byte values
  localparam logic [7:0] BYTE_FF  = 8'hff;
  localparam logic [7:0] BYTE_SOI = 8'hd8;
  localparam logic [7:0] BYTE_EOI = 8'hd9;
  localparam logic [7:0] BYTE_APP0 = 8'he0;
  localparam logic [7:0] BYTE_APP1 = 8'he1;

  // Nesting depth saturates at this value
  localparam int NEST_LIMIT = 255;
  localparam int NEST_W     = $clog2(NEST_LIMIT + 1);

  // Up to four result beats per input beat
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  localparam int OFFSET_W = 32;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       image_start;
    logic       image_end;
    logic       truncated;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic last;
  } outq_status_t;

endpackage

// ----- hw/rtl/jsc_if.sv -----
// Interfaces: input byte channel, result channel and configuration write channel.
interface jsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface jsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       image_start;
  logic       image_end;
  logic       truncated;
  logic       last_of_run;
  modport source (output valid, output out_byte, output image_start, output image_end,
                  output truncated, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input image_start, input image_end,
                input truncated, input last_of_run, output ready);
endinterface

interface jsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_offset;
  modport source (output valid, output start_offset, input ready);
  modport sink (input valid, input start_offset, output ready);
endinterface

// ----- hw/rtl/jsc_outq.sv -----
// Result buffer: holds one input byte's beats and hands them out one a cycle while ready.
module jsc_outq
  import jsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [CNT_W-1:0]  count_i,
  input  out_item_t         items_i [MAX_RESULTS],
  output outq_status_t      status_o,
  jsc_out_if.source         out_o
);

  out_item_t        items_q [MAX_RESULTS];
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] rd_q;
  logic             pop;
  out_item_t        head;

  assign head            = items_q[rd_q];
  assign status_o.busy   = (count_q != '0);
  assign status_o.last   = (rd_q == IDX_W'(count_q - CNT_W'(1)));
  assign pop             = out_o.valid && out_o.ready;

  assign out_o.valid       = status_o.busy;
  assign out_o.out_byte    = head.out_byte;
  assign out_o.image_start = head.image_start;
  assign out_o.image_end   = head.image_end;
  assign out_o.truncated   = head.truncated;
  assign out_o.last_of_run = head.last_of_run;

  // Advance the read index, drop the bundle after its last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= '0;
    end else if (load_i) begin
      count_q <= count_i;
      rd_q    <= '0;
    end else if (pop) begin
      if (status_o.last) begin
        count_q <= '0;
      end else begin
        rd_q <= rd_q + IDX_W'(1);
      end
    end
  end

  // Hold the payload of the current bundle
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      items_q <= items_i;
    end
  end

endmodule

// ----- hw/rtl/jpeg_stream_carver.sv -----
// Top level: carves JPEG images out of a raw byte stream.
// One input byte is taken per cycle while the result buffer is empty or hands out its
// last beat. Each byte causes zero, one, two or four result beats; they leave from a
// result buffer at one beat per cycle while the output is ready, and the next byte is
// taken in the cycle the last of them leaves. Bytes that cause no beat or one beat
// stream at one per cycle while the output is ready. The first start_offset bytes of
// each stream are skipped; after a byte marked stream_end all scan state returns to
// reset. The offset is written over the cfg channel, which is always ready.
module jpeg_stream_carver
  import jsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  jsc_cfg_if.sink    cfg_i,
  jsc_in_if.sink     in_i,
  jsc_out_if.source  out_o
);

  typedef enum logic [1:0] {
    SCAN_FF1,
    SCAN_SOI,
    SCAN_FF2,
    SCAN_APP
  } scan_stage_e;

  logic [OFFSET_W-1:0] offset_q;
  scan_stage_e         scan_q, scan_d;
  logic                in_image_q, in_image_d;
  logic                pend_q, pend_d;
  logic [NEST_W-1:0]   depth_q, depth_d;
  logic [OFFSET_W-1:0] pos_q, pos_d;

  out_item_t           items [MAX_RESULTS];
  logic [CNT_W-1:0]    count;
  logic                closed;
  logic                in_acc;
  outq_status_t        qstat;

  // Take a new byte when the buffer is empty or hands out its last beat now
  assign in_i.ready = !qstat.busy || (out_o.ready && qstat.last);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Work out the beats and next scan state for the byte on the input
  always_comb begin
    scan_d     = scan_q;
    in_image_d = in_image_q;
    pend_d     = pend_q;
    depth_d    = depth_q;
    pos_d      = pos_q;
    count      = '0;
    closed     = 1'b0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      items[k] = '0;
    end

    if (pos_q < offset_q) begin
      pos_d = pos_q + OFFSET_W'(1);
    end else if (!in_image_q) begin
      unique case (scan_q)
        SCAN_FF1: scan_d = (in_i.in_byte == BYTE_FF)  ? SCAN_SOI : SCAN_FF1;
        SCAN_SOI: scan_d = (in_i.in_byte == BYTE_SOI) ? SCAN_FF2 : SCAN_FF1;
        SCAN_FF2: scan_d = (in_i.in_byte == BYTE_FF)  ? SCAN_APP : SCAN_FF1;
        SCAN_APP: begin
          scan_d = SCAN_FF1;
          if (in_i.in_byte == BYTE_APP0 || in_i.in_byte == BYTE_APP1) begin
            items[0].out_byte    = BYTE_FF;
            items[0].image_start = 1'b1;
            items[1].out_byte    = BYTE_SOI;
            items[2].out_byte    = BYTE_FF;
            items[3].out_byte    = in_i.in_byte;
            count      = CNT_W'(4);
            in_image_d = 1'b1;
            pend_d     = 1'b0;
            depth_d    = NEST_W'(1);
          end
        end
        default: scan_d = SCAN_FF1;
      endcase
    end else if (!pend_q) begin
      if (in_i.in_byte == BYTE_FF) begin
        pend_d = 1'b1;
        if (in_i.stream_end) begin
          items[0].out_byte = BYTE_FF;
          count = CNT_W'(1);
        end
      end else begin
        items[0].out_byte = in_i.in_byte;
        count = CNT_W'(1);
      end
    end else begin
      pend_d = 1'b0;
      items[0].out_byte = BYTE_FF;
      items[1].out_byte = in_i.in_byte;
      count = CNT_W'(2);
      if (in_i.in_byte == BYTE_SOI) begin
        if (depth_q < NEST_W'(NEST_LIMIT)) begin
          depth_d = depth_q + NEST_W'(1);
        end
      end else if (in_i.in_byte == BYTE_EOI) begin
        if (depth_q > NEST_W'(1)) begin
          depth_d = depth_q - NEST_W'(1);
        end else begin
          depth_d            = '0;
          items[1].image_end = 1'b1;
          in_image_d         = 1'b0;
          closed             = 1'b1;
        end
      end
    end

    // Flag truncation and last beat of the run
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (count == CNT_W'(k + 1)) begin
        items[k].last_of_run = 1'b1;
        if (in_i.stream_end && in_image_d && !closed) begin
          items[k].image_end = 1'b1;
          items[k].truncated = 1'b1;
        end
      end
    end

    // Return to reset at the end of a stream
    if (in_i.stream_end) begin
      scan_d     = SCAN_FF1;
      in_image_d = 1'b0;
      pend_d     = 1'b0;
      depth_d    = '0;
      pos_d      = '0;
    end
  end

  // Hold scan state and the offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      scan_q     <= SCAN_FF1;
      in_image_q <= 1'b0;
      pend_q     <= 1'b0;
      depth_q    <= '0;
      pos_q      <= '0;
    end else begin
      if (cfg_i.valid) begin
        offset_q <= cfg_i.start_offset;
      end
      if (in_acc) begin
        scan_q     <= scan_d;
        in_image_q <= in_image_d;
        pend_q     <= pend_d;
        depth_q    <= depth_d;
        pos_q      <= pos_d;
      end
    end
  end

  jsc_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_acc),
    .count_i  (count),
    .items_i  (items),
    .status_o (qstat),
    .out_o    (out_o)
  );

  // Depth is non-zero exactly while an image is open
  a_depth_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_image_q == (depth_q != '0))
    else $error("nesting depth disagrees with image state");

  // A pending marker and header scanning only make sense in their own mode
  a_pend_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q |-> in_image_q) and (scan_q != SCAN_FF1 |-> !in_image_q))
    else $error("marker or scan state outside its mode");

  // An image start beat is the header FF and never closes a run
  a_start_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.image_start) |-> (out_o.out_byte == BYTE_FF && !out_o.last_of_run))
    else $error("bad image start beat");

  // A byte is taken only when the buffer is free or drains this cycle
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!qstat.busy || (out_o.valid && out_o.ready && out_o.last_of_run)))
    else $error("input accepted over undelivered beats");

endmodule

// ----- verif/tb_jpeg_stream_carver.sv -----
// Testbench for the JPEG stream carver: directed and random byte streams checked beat by beat.
module tb_jpeg_stream_carver;
  timeunit 1ns;
  timeprecision 1ps;
  import jsc_pkg::*;

  // Header hunt stages while outside an image
  typedef enum logic [1:0] {
    HUNT_FF,
    HUNT_SOI,
    HUNT_FF2,
    HUNT_APP
  } hunt_e;

  typedef struct {
    logic [7:0] in_byte;
    logic       stream_end;
  } stream_beat_t;

  // Carver behaviour mirrored in software, plus the queue of beats still owed
  class carve_scoreboard;
    logic [31:0]  skip_len;
    logic [31:0]  pos;
    hunt_e        hunt;
    bit           img_open;
    bit           ff_held;
    int unsigned  nest;
    out_item_t    owed_q[$];
    int unsigned  errors;

    function new();
      skip_len = '0;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      pos      = '0;
      hunt     = HUNT_FF;
      img_open = 1'b0;
      ff_held  = 1'b0;
      nest     = 0;
    endfunction

    function void set_offset(logic [31:0] v);
      skip_len = v;
    endfunction

    function out_item_t carved(logic [7:0] b, logic first);
      out_item_t r;
      r.out_byte    = b;
      r.image_start = first;
      r.image_end   = 1'b0;
      r.truncated   = 1'b0;
      r.last_of_run = 1'b0;
      return r;
    endfunction

    // Work out the beats one accepted stream byte causes
    function void note_input(logic [7:0] b, logic e);
      out_item_t run [MAX_RESULTS];
      int        n;
      bit        closed;
      n      = 0;
      closed = 1'b0;
      // drop the leading bytes of each stream
      if (pos < skip_len) begin
        pos++;
        if (e) restart();
        return;
      end
      if (!img_open) begin
        case (hunt)
          HUNT_FF:  hunt = (b == BYTE_FF) ? HUNT_SOI : HUNT_FF;
          HUNT_SOI: hunt = (b == BYTE_SOI) ? HUNT_FF2 : HUNT_FF;
          HUNT_FF2: hunt = (b == BYTE_FF) ? HUNT_APP : HUNT_FF;
          default: begin
            if (b == BYTE_APP0 || b == BYTE_APP1) begin
              run[0]   = carved(BYTE_FF, 1'b1);
              run[1]   = carved(BYTE_SOI, 1'b0);
              run[2]   = carved(BYTE_FF, 1'b0);
              run[3]   = carved(b, 1'b0);
              n        = 4;
              img_open = 1'b1;
              ff_held  = 1'b0;
              nest     = 1;
            end
            hunt = HUNT_FF;
          end
        endcase
      end else if (!ff_held) begin
        if (b == BYTE_FF) begin
          ff_held = 1'b1;
          // a marker byte that ends the stream goes out alone
          if (e) begin
            run[0] = carved(BYTE_FF, 1'b0);
            n      = 1;
          end
        end else begin
          run[0] = carved(b, 1'b0);
          n      = 1;
        end
      end else begin
        ff_held = 1'b0;
        run[0]  = carved(BYTE_FF, 1'b0);
        run[1]  = carved(b, 1'b0);
        n       = 2;
        if (b == BYTE_SOI) begin
          if (nest < NEST_LIMIT) nest++;
        end else if (b == BYTE_EOI) begin
          if (nest > 0) nest--;
          if (nest == 0) begin
            run[1].image_end = 1'b1;
            img_open         = 1'b0;
            closed           = 1'b1;
          end
        end
      end
      if (e) begin
        if (img_open && !closed && n > 0) begin
          run[n-1].image_end = 1'b1;
          run[n-1].truncated = 1'b1;
        end
        restart();
      end
      if (n > 0) run[n-1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++) owed_q.push_back(run[k]);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat with the oldest owed beat
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: out_byte %0h", got.out_byte);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("image_start", 8'(want.image_start), 8'(got.image_start));
      cmp_field("image_end", 8'(want.image_end), 8'(got.image_end));
      cmp_field("truncated", 8'(want.truncated), 8'(got.truncated));
      cmp_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  jsc_in_if  in_if ();
  jsc_out_if out_if ();
  jsc_cfg_if cfg_if ();

  jpeg_stream_carver dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  carve_scoreboard sb;
  stream_beat_t    stim_q[$];
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct     = 0;
  int unsigned     hold_left     = 0;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Give up after a generous time
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Drive ready on the falling edge; a hold-off keeps it low for a counted stretch
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Sample every handshake on the rising edge, in a fixed order
  always @(posedge clk) begin
    out_item_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_offset(cfg_if.start_offset);
      if (in_if.valid && in_if.ready) sb.note_input(in_if.in_byte, in_if.stream_end);
      if (out_if.valid && out_if.ready) begin
        got.out_byte    = out_if.out_byte;
        got.image_start = out_if.image_start;
        got.image_end   = out_if.image_end;
        got.truncated   = out_if.truncated;
        got.last_of_run = out_if.last_of_run;
        sb.check_result(got);
      end
    end
  end

  // Stream builders
  function automatic void queue_byte(logic [7:0] b, logic e);
    stream_beat_t s;
    s.in_byte    = b;
    s.stream_end = e;
    stim_q.push_back(s);
  endfunction

  function automatic void end_stream();
    if (stim_q.size() > 0) stim_q[stim_q.size()-1].stream_end = 1'b1;
  endfunction

  function automatic void queue_noise(int unsigned n);
    for (int k = 0; k < n; k++)
      queue_byte(($urandom_range(4) == 0) ? BYTE_FF : 8'($urandom_range(255)), 1'b0);
  endfunction

  // Header that may break off somewhere after its first byte
  function automatic void queue_broken_header();
    queue_byte(BYTE_FF, 1'b0);
    queue_byte($urandom_range(1) ? BYTE_SOI : 8'($urandom_range(255)), 1'b0);
    queue_byte($urandom_range(1) ? BYTE_FF : 8'($urandom_range(255)), 1'b0);
    queue_byte(8'($urandom_range(255)), 1'b0);
  endfunction

  // Well-formed image with random body; cut ends the stream inside it
  function automatic void queue_image(bit cut);
    int unsigned lvl;
    int unsigned body;
    int unsigned pick;
    logic [7:0]  b;
    lvl = 1;
    queue_byte(BYTE_FF, 1'b0);
    queue_byte(BYTE_SOI, 1'b0);
    queue_byte(BYTE_FF, 1'b0);
    queue_byte($urandom_range(1) ? BYTE_APP1 : BYTE_APP0, 1'b0);
    body = $urandom_range(10);
    for (int k = 0; k < body; k++) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        queue_byte(8'($urandom_range(254)), 1'b0);
      end else begin
        if (pick < 6) b = 8'($urandom_range(255));
        else if (pick < 8) b = BYTE_SOI;
        else b = BYTE_EOI;
        queue_byte(BYTE_FF, 1'b0);
        queue_byte(b, 1'b0);
        if (b == BYTE_SOI) begin
          lvl++;
        end else if (b == BYTE_EOI) begin
          lvl--;
          if (lvl == 0) return;
        end
      end
    end
    if (cut) begin
      if ($urandom_range(1)) queue_byte(BYTE_FF, 1'b1);
      else end_stream();
      return;
    end
    while (lvl > 0) begin
      queue_byte(BYTE_FF, 1'b0);
      queue_byte(BYTE_EOI, 1'b0);
      lvl--;
    end
  endfunction

  function automatic void build_random(int unsigned n);
    int unsigned pick;
    while (stim_q.size() < n) begin
      pick = $urandom_range(9);
      if (pick < 6) queue_image(1'b0);
      else if (pick == 6) queue_image(1'b1);
      else if (pick == 7) queue_broken_header();
      else queue_noise($urandom_range(1, 6));
      if ($urandom_range(6) == 0) end_stream();
    end
    end_stream();
  endfunction

  function automatic void queue_directed();
    // header with APP0, then FF FF, nest up, nest down, plain byte, close
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_SOI, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_APP0, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_FF, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_SOI, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_EOI, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_EOI, 1'b0);
    // failing FF in the fourth header slot is not looked at again
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_SOI, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_FF, 1'b0);
    // header with APP1, then the stream ends on a lone marker byte
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_SOI, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_APP1, 1'b0);
    queue_byte(BYTE_FF, 1'b1);
    // stream ends on the last header byte
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_SOI, 1'b0);
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_APP0, 1'b1);
    // stream ends while hunting for a header
    queue_byte(BYTE_FF, 1'b0);  queue_byte(BYTE_SOI, 1'b1);
  endfunction

  // Offer one beat after a random idle spell and hold it until taken
  task automatic send_beat(stream_beat_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.in_byte    = s.in_byte;
    in_if.stream_end = s.stream_end;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_queued(int unsigned n);
    repeat (n) begin
      if (stim_q.size() > 0) send_beat(stim_q.pop_front());
    end
  endtask

  task automatic send_all();
    while (stim_q.size() > 0) send_beat(stim_q.pop_front());
  endtask

  // Drop valid and wait for every owed beat
  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_offset(logic [31:0] v);
    @(negedge clk);
    cfg_if.valid        = 1'b1;
    cfg_if.start_offset = v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    @(posedge clk);
  endtask

  // Let the block go quiet before touching the offset
  task automatic settle_and_write(logic [31:0] v);
    drain_results();
    repeat (8) @(posedge clk);
    write_offset(v);
  endtask

  task automatic run_phase(logic [31:0] offset, int unsigned idle, int unsigned stall,
                           int unsigned n);
    settle_and_write(offset);
    send_idle_pct = idle;
    stall_pct     = stall;
    build_random(n);
    send_all();
  endtask

  initial begin
    sb                  = new();
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.stream_end    = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.start_offset = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed cases
    write_offset('0);
    queue_directed();
    send_all();

    // back-pressure: long hold-off while bytes keep coming, then a full pause
    settle_and_write(32'd2);
    send_idle_pct = 0;
    stall_pct     = 0;
    build_random(100);
    send_queued(20);
    hold_left = 200;
    send_queued(50);
    drain_results();
    send_all();

    // widest offset skips everything
    settle_and_write(32'hffff_ffff);
    send_idle_pct = 31;
    stall_pct     = 31;
    queue_image(1'b0);
    queue_noise(6);
    end_stream();
    queue_image(1'b0);
    send_all();

    run_phase(32'd0, 75, 0, 60);
    run_phase(32'($urandom_range(1, 8)), 0, 75, 60);
    run_phase(32'($urandom_range(0, 3)), 31, 31, 60);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/jsc_pkg.sv
hw/rtl/jsc_if.sv
hw/rtl/jsc_outq.sv
hw/rtl/jpeg_stream_carver.sv
verif/tb_jpeg_stream_carver.sv
